// File: rtl/pqkill_pkg.sv
package pqkill_pkg;

	// Queue size and the widths that follow from it.
	localparam int QUEUE_DEPTH = 16;
	localparam int ADDR_W      = $clog2(QUEUE_DEPTH);
	localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

	// Operation codes.
	localparam logic [1:0] CMD_INSERT = 2'd0;
	localparam logic [1:0] CMD_POP    = 2'd1;
	localparam logic [1:0] CMD_KILL   = 2'd2;

	// Status codes.
	localparam logic [1:0] STAT_OK        = 2'd0;
	localparam logic [1:0] STAT_EMPTY     = 2'd1;
	localparam logic [1:0] STAT_NOT_FOUND = 2'd2;
	localparam logic [1:0] STAT_FULL      = 2'd3;

	// One stored queue entry.
	typedef struct packed {
		logic [15:0]        proc_id;
		logic signed [15:0] prio;
	} pqkill_entry_t;

	// Request beat.
	typedef struct packed {
		logic [1:0]         cmd;
		logic [15:0]        proc_id;
		logic signed [15:0] prio;
	} pqkill_req_t;

	// Response beat.
	typedef struct packed {
		logic [1:0]         status;
		logic [15:0]        out_id;
		logic signed [15:0] out_prio;
		logic [4:0]         occupancy;
	} pqkill_rsp_t;

	// Sequencer states.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_INS,
		ST_REM,
		ST_DONE
	} pqkill_state_t;

endpackage

// File: rtl/priority_queue_with_kill_by_id_unit.sv
// Sorted priority queue with removal by process id.
// The request channel (req_valid, req_stall, req) carries one operation per beat:
// insert an entry in priority order, pop the head, or kill the first entry whose
// id matches. Every request beat produces exactly one response beat on the
// response channel (rsp_valid, rsp_stall, rsp) with a status, the removed entry
// and the occupancy after the operation.
// The entries live in a single memory with one read and one write port and a
// registered read. Insert walks from the tail toward the head, moving each larger
// entry up by one; pop and kill walk from the head, closing the gap behind the
// removed entry. One entry is read per cycle. Pop and kill always scan every
// entry up to the occupancy; insert stops early at its slot; a full-queue insert
// or an unused code skips the scan and goes straight to the response.
// Only one item is in work at a time; req_stall is high
// from acceptance until its response is loaded into the output register.
// The output register lets a new request be accepted while the last response
// is still held by rsp_stall; the held beat does not change.
// Reset empties the queue at once; memory contents are not cleared and are never
// read above the occupancy.
module priority_queue_with_kill_by_id_unit
	import pqkill_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_stall,
	input  pqkill_req_t req,
	output logic        rsp_valid,
	input  logic        rsp_stall,
	output pqkill_rsp_t rsp
);

	pqkill_state_t state_q, state_d;

	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  rd_idx_q;
	logic [CNT_W-1:0]  rd_prev;
	logic [1:0]        cmd_q;
	logic [15:0]       id_q;
	logic signed [15:0] prio_q;
	logic [1:0]        st_q;
	pqkill_entry_t     hit_q;
	logic              found_q;
	logic              rsp_valid_q;
	pqkill_rsp_t       rsp_q;

	logic              vld_s1;
	logic [ADDR_W-1:0] idx_s1;
	pqkill_entry_t     rd_data_s1;

	logic              rd_en;
	logic [ADDR_W-1:0] rd_addr;
	logic              wr_en;
	logic [ADDR_W-1:0] wr_addr;
	pqkill_entry_t     wr_data;
	logic              scan_end;
	logic              hit_now;
	logic              accept;
	logic              is_full;
	logic              rsp_load;

	pqkill_entry_t     mem [QUEUE_DEPTH];

	assign accept    = req_valid && !req_stall;
	assign req_stall = (state_q != ST_IDLE);
	assign is_full   = (count_q == CNT_W'(QUEUE_DEPTH));
	assign rsp_load  = (state_q == ST_DONE) && (!rsp_valid_q || !rsp_stall);
	assign rd_prev   = rd_idx_q - CNT_W'(1);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					if (req.cmd == CMD_INSERT) begin
						state_d = is_full ? ST_DONE : ST_INS;
					end else if (req.cmd == CMD_POP || req.cmd == CMD_KILL) begin
						state_d = ST_REM;
					end else begin
						state_d = ST_DONE;
					end
				end
			end
			ST_INS, ST_REM: begin
				if (scan_end) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (rsp_load) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Memory access and scan control for the current state.
	always_comb begin
		rd_en    = 1'b0;
		rd_addr  = '0;
		wr_en    = 1'b0;
		wr_addr  = '0;
		wr_data  = '{proc_id: id_q, prio: prio_q};
		scan_end = 1'b0;
		hit_now  = 1'b0;
		case (state_q)
			ST_INS: begin
				// Larger entries move up one slot; the new entry lands above the
				// first entry that is not larger, or at the head.
				if (vld_s1) begin
					wr_en   = 1'b1;
					wr_addr = idx_s1 + ADDR_W'(1);
					if (rd_data_s1.prio > prio_q) begin
						wr_data = rd_data_s1;
					end else begin
						scan_end = 1'b1;
					end
				end else if (rd_idx_q == '0) begin
					wr_en    = 1'b1;
					wr_addr  = '0;
					scan_end = 1'b1;
				end
				if (!scan_end && rd_idx_q != '0) begin
					rd_en   = 1'b1;
					rd_addr = rd_prev[ADDR_W-1:0];
				end
			end
			ST_REM: begin
				// The first matching entry is taken out; later entries move down.
				if (vld_s1) begin
					if (found_q) begin
						wr_en   = 1'b1;
						wr_addr = idx_s1 - ADDR_W'(1);
						wr_data = rd_data_s1;
					end else if (cmd_q == CMD_POP) begin
						hit_now = (idx_s1 == '0);
					end else begin
						hit_now = (rd_data_s1.proc_id == id_q);
					end
				end
				if (rd_idx_q < count_q) begin
					rd_en   = 1'b1;
					rd_addr = rd_idx_q[ADDR_W-1:0];
				end
				scan_end = (rd_idx_q == count_q) && !vld_s1;
			end
			default: begin
				rd_en = 1'b0;
			end
		endcase
	end

	// Entry memory: one write and one registered read per cycle.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_s1 <= mem[rd_addr];
		end
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			rd_idx_q    <= '0;
			found_q     <= 1'b0;
			vld_s1      <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			rsp_valid_q <= rsp_load || (rsp_valid_q && rsp_stall);
			if (accept) begin
				found_q  <= 1'b0;
				vld_s1   <= 1'b0;
				rd_idx_q <= (req.cmd == CMD_INSERT) ? count_q : '0;
			end else if (state_q == ST_INS || state_q == ST_REM) begin
				vld_s1 <= rd_en && !scan_end;
				if (hit_now) begin
					found_q <= 1'b1;
				end
				if (rd_en) begin
					rd_idx_q <= (state_q == ST_INS) ? rd_prev : rd_idx_q + CNT_W'(1);
				end
				if (scan_end && state_q == ST_INS) begin
					count_q <= count_q + CNT_W'(1);
				end
				if (scan_end && state_q == ST_REM && found_q) begin
					count_q <= count_q - CNT_W'(1);
				end
			end
		end
	end

	// Operation operands, scan pipeline and result payload.
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q  <= req.cmd;
			id_q   <= req.proc_id;
			prio_q <= req.prio;
			hit_q  <= '0;
			st_q   <= (req.cmd == CMD_INSERT && is_full) ? STAT_FULL : STAT_OK;
		end else begin
			if (state_q == ST_INS || state_q == ST_REM) begin
				idx_s1 <= rd_addr;
			end
			if (hit_now) begin
				hit_q <= rd_data_s1;
			end
			if (state_q == ST_REM && scan_end && !found_q) begin
				st_q <= (cmd_q == CMD_POP) ? STAT_EMPTY : STAT_NOT_FOUND;
			end
		end
		if (rsp_load) begin
			rsp_q <= '{status: st_q, out_id: hit_q.proc_id, out_prio: hit_q.prio,
				occupancy: 5'(count_q)};
		end
	end

`ifndef ASSERT_OFF
	// The occupancy never goes beyond the queue size.
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(QUEUE_DEPTH))
		else $error("queue occupancy above depth");

	// The memory is written only while a scan is in progress.
	a_write_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (state_q == ST_INS || state_q == ST_REM))
		else $error("memory write outside a scan");

	// A successful removal lowers the occupancy by exactly one.
	a_remove_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_REM && scan_end && found_q) |=> count_q == $past(count_q) - CNT_W'(1))
		else $error("removal did not lower occupancy by one");

	// A response that reports a failure carries no entry.
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && (rsp.status == STAT_EMPTY || rsp.status == STAT_NOT_FOUND ||
		rsp.status == STAT_FULL)) |-> (rsp.out_id == '0 && rsp.out_prio == '0))
		else $error("failed operation returned an entry");
`endif

endmodule
